// ===== hw/rtl/rwap_pkg.sv =====
// Package for the reaction wheel attitude controller: constants, types and codes.
`default_nettype none

package rwap_pkg;

   // Field widths of the transactions.
   localparam int IN_W   = 16;  // angle and rate fields
   localparam int GAIN_W = 12;
   localparam int ILIM_W = 15;
   localparam int TLIM_W = 14;
   localparam int DUTY_W = 14;

   // Internal widths.
   localparam int E_W    = IN_W + 1;    // angle error
   localparam int S_W    = IN_W + 2;    // integral plus error before the clamp
   localparam int P_W    = 30;          // one gain product
   localparam int U_W    = 31;          // axis command
   localparam int T_W    = 48;          // wheel torque scaled by 2^23
   localparam int TORQUE_SHIFT = 23;
   localparam int Q_W    = T_W - TORQUE_SHIFT;
   localparam int M_W    = Q_W + 1;     // rounded-up torque magnitude
   localparam int D_W    = 18;          // signed duty before saturation

   // Allocation matrix coefficients, Q0.16.
   localparam logic [15:0] COEF_A = 16'd39525;
   localparam logic [14:0] COEF_B = 15'd29301;

   localparam logic [15:0]       PWM_FULL_SCALE = 16'd8399;
   localparam logic [DUTY_W-1:0] DUTY_MAX       = '1;

   localparam int NUM_WHEELS = 4;
   localparam int NUM_AXES   = 2;

   // Register indexes of the configuration port.
   typedef enum logic [2:0] {
      REG_ROLL_TARGET    = 3'd0,
      REG_PITCH_TARGET   = 3'd1,
      REG_PROP_GAIN      = 3'd2,
      REG_INTEG_GAIN     = 3'd3,
      REG_RATE_GAIN      = 3'd4,
      REG_INTEGRAL_LIMIT = 3'd5,
      REG_TORQUE_LIMIT   = 3'd6,
      REG_WHEELS_ENABLED = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic signed [IN_W-1:0] roll_target;
      logic signed [IN_W-1:0] pitch_target;
      logic [GAIN_W-1:0]      prop_gain;
      logic [GAIN_W-1:0]      integ_gain;
      logic [GAIN_W-1:0]      rate_gain;
      logic [ILIM_W-1:0]      integral_limit;
      logic [TLIM_W-1:0]      torque_limit;
      logic                   wheels_enabled;
   } cfg_type;

   // One strobe for each step of the computation, driven by the sequencer.
   typedef struct packed {
      logic accept;
      logic mul;
      logic sum;
      logic wmul;
      logic wsum;
      logic mag;
   } step_type;

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_MUL  = 7'b0000010,
      ST_SUM  = 7'b0000100,
      ST_WMUL = 7'b0001000,
      ST_WSUM = 7'b0010000,
      ST_MAG  = 7'b0100000,
      ST_OUT  = 7'b1000000
   } state_type;

endpackage

`default_nettype wire

// ===== hw/rtl/rwap_if.sv =====
// Channel interfaces for the sensor transaction and the wheel command transaction.
`default_nettype none

interface rwap_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] roll_angle;
   logic signed [15:0] pitch_angle;
   logic signed [15:0] roll_rate;
   logic signed [15:0] pitch_rate;
   logic signed [15:0] yaw_rate;

   modport source (output valid, roll_angle, pitch_angle, roll_rate, pitch_rate, yaw_rate,
                   input ready);
   modport sink (input valid, roll_angle, pitch_angle, roll_rate, pitch_rate, yaw_rate,
                 output ready);
endinterface

interface rwap_rsp_if;
   logic        valid;
   logic        ready;
   logic [13:0] duty_wheel0;
   logic [13:0] duty_wheel1;
   logic [13:0] duty_wheel2;
   logic [13:0] duty_wheel3;
   logic        dir_wheel0;
   logic        dir_wheel1;
   logic        dir_wheel2;
   logic        dir_wheel3;
   logic        motor_enable;

   modport source (output valid, duty_wheel0, duty_wheel1, duty_wheel2, duty_wheel3,
                   dir_wheel0, dir_wheel1, dir_wheel2, dir_wheel3, motor_enable,
                   input ready);
   modport sink (input valid, duty_wheel0, duty_wheel1, duty_wheel2, duty_wheel3,
                 dir_wheel0, dir_wheel1, dir_wheel2, dir_wheel3, motor_enable,
                 output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/rwap_csr.sv =====
// Configuration register file behind an APB-style port.
`default_nettype none

module rwap_csr import rwap_pkg::*; (
   input  wire         clock,
   input  wire         reset,
   input  wire         csr_psel,
   input  wire         csr_penable,
   input  wire         csr_pwrite,
   input  wire  [4:0]  csr_paddr,
   input  wire  [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output cfg_type     cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type index;
   logic          write;

   assign index      = reg_index_type'(csr_paddr[4:2]);
   assign write      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write) begin
         case (index)
            REG_ROLL_TARGET:    cfg_in.roll_target    = csr_pwdata[IN_W-1:0];
            REG_PITCH_TARGET:   cfg_in.pitch_target   = csr_pwdata[IN_W-1:0];
            REG_PROP_GAIN:      cfg_in.prop_gain      = csr_pwdata[GAIN_W-1:0];
            REG_INTEG_GAIN:     cfg_in.integ_gain     = csr_pwdata[GAIN_W-1:0];
            REG_RATE_GAIN:      cfg_in.rate_gain      = csr_pwdata[GAIN_W-1:0];
            REG_INTEGRAL_LIMIT: cfg_in.integral_limit = csr_pwdata[ILIM_W-1:0];
            REG_TORQUE_LIMIT:   cfg_in.torque_limit   = csr_pwdata[TLIM_W-1:0];
            REG_WHEELS_ENABLED: cfg_in.wheels_enabled = csr_pwdata[0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.roll_target    <= '0;
         cfg_ff.pitch_target   <= '0;
         cfg_ff.prop_gain      <= GAIN_W'(800);
         cfg_ff.integ_gain     <= '0;
         cfg_ff.rate_gain      <= GAIN_W'(240);
         cfg_ff.integral_limit <= ILIM_W'(2560);
         cfg_ff.torque_limit   <= TLIM_W'(4000);
         cfg_ff.wheels_enabled <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Targets read back sign-extended.
   always_comb begin
      case (index)
         REG_ROLL_TARGET:    csr_prdata = 32'(cfg_ff.roll_target);
         REG_PITCH_TARGET:   csr_prdata = 32'(cfg_ff.pitch_target);
         REG_PROP_GAIN:      csr_prdata = {20'b0, cfg_ff.prop_gain};
         REG_INTEG_GAIN:     csr_prdata = {20'b0, cfg_ff.integ_gain};
         REG_RATE_GAIN:      csr_prdata = {20'b0, cfg_ff.rate_gain};
         REG_INTEGRAL_LIMIT: csr_prdata = {17'b0, cfg_ff.integral_limit};
         REG_TORQUE_LIMIT:   csr_prdata = {18'b0, cfg_ff.torque_limit};
         REG_WHEELS_ENABLED: csr_prdata = {31'b0, cfg_ff.wheels_enabled};
         default:            csr_prdata = '0;
      endcase
   end

endmodule

`default_nettype wire

// ===== hw/rtl/rwap_axis_lane.sv =====
// One axis of the PID: error, clamped integral, three gain products and their sum.
`default_nettype none

module rwap_axis_lane import rwap_pkg::*; (
   input  wire                        clock,
   input  wire                        reset,
   input  wire step_type              step,
   input  wire cfg_type               cfg,
   input  wire signed [IN_W-1:0]      angle,
   input  wire signed [IN_W-1:0]      target,
   input  wire signed [IN_W-1:0]      rate,
   output logic signed [U_W-1:0]      u
);

   logic signed [E_W-1:0]  err;
   logic signed [S_W-1:0]  acc;
   logic signed [S_W-1:0]  lim;
   logic signed [S_W-1:0]  clamped;

   logic signed [IN_W-1:0] integ_ff;
   logic signed [E_W-1:0]  e_ff;
   logic signed [IN_W-1:0] s_ff;
   logic signed [IN_W-1:0] rate_ff;
   logic signed [P_W-1:0]  pe_ff, pi_ff, pr_ff;
   logic signed [P_W-1:0]  pe_in, pi_in, pr_in;
   logic signed [U_W-1:0]  u_ff, u_in;

   assign err = $signed({angle[IN_W-1], angle}) - $signed({target[IN_W-1], target});
   assign acc = $signed({{2{integ_ff[IN_W-1]}}, integ_ff}) + $signed({err[E_W-1], err});
   assign lim = $signed({{(S_W-ILIM_W){1'b0}}, cfg.integral_limit});

   always_comb begin
      if (acc > lim) begin
         clamped = lim;
      end else if (acc < -lim) begin
         clamped = -lim;
      end else begin
         clamped = acc;
      end
   end

   // The integral is updated before it feeds the command of the same transaction.
   always_ff @(posedge clock) begin
      if (reset) begin
         integ_ff <= '0;
      end else if (step.accept) begin
         integ_ff <= clamped[IN_W-1:0];
      end
   end

   assign pe_in = $signed({1'b0, cfg.prop_gain}) * e_ff;
   assign pi_in = $signed({1'b0, cfg.integ_gain}) * s_ff;
   assign pr_in = $signed({1'b0, cfg.rate_gain}) * rate_ff;
   assign u_in  = U_W'(pe_ff) + U_W'(pi_ff) + U_W'(pr_ff);

   always_ff @(posedge clock) begin
      if (step.accept) begin
         e_ff    <= err;
         s_ff    <= clamped[IN_W-1:0];
         rate_ff <= rate;
      end
      if (step.mul) begin
         pe_ff <= pe_in;
         pi_ff <= pi_in;
         pr_ff <= pr_in;
      end
      if (step.sum) begin
         u_ff <= u_in;
      end
   end

   assign u = u_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/rwap_wheel_lane.sv =====
// One wheel: allocation products, torque sum, rounded magnitude with limit, duty value.
`default_nettype none

module rwap_wheel_lane import rwap_pkg::*; (
   input  wire                   clock,
   input  wire step_type         step,
   input  wire cfg_type          cfg,
   input  wire signed [U_W-1:0]  u_axis,
   input  wire signed [U_W-1:0]  u_damp,
   input  wire                   neg_axis,
   output logic [DUTY_W-1:0]     duty,
   output logic                  dir
);

   logic signed [T_W-1:0] pa_ff, pa_in;
   logic signed [T_W-1:0] pb_ff, pb_in;
   logic signed [T_W-1:0] t_ff, t_in;
   logic [M_W-1:0]        mag_full;
   logic [TLIM_W-1:0]     mag_ff, mag_in;
   logic                  dir_ff, dir_in;
   logic                  frac_nz;
   logic signed [D_W-1:0] diff;

   // A disabled block drives zero torque on every wheel.
   always_comb begin
      if (cfg.wheels_enabled) begin
         pa_in = $signed({1'b0, COEF_A}) * u_axis;
         pb_in = $signed({1'b0, COEF_B}) * u_damp;
      end else begin
         pa_in = '0;
         pb_in = '0;
      end
   end

   // u_damp is the positive rate term; the yaw command is its negation.
   always_comb begin
      if (neg_axis) begin
         t_in = -pa_ff - pb_ff;
      end else begin
         t_in = pa_ff - pb_ff;
      end
   end

   // Rounded-up magnitude of the torque in PWM counts. For a negative torque the
   // arithmetic shift already rounds toward minus infinity, so its negation rounds up.
   assign frac_nz = |t_ff[TORQUE_SHIFT-1:0];

   always_comb begin
      if (!t_ff[T_W-1]) begin
         mag_full = {1'b0, t_ff[T_W-1:TORQUE_SHIFT]} + {{(M_W-1){1'b0}}, frac_nz};
      end else begin
         mag_full = M_W'(0) - {t_ff[T_W-1], t_ff[T_W-1:TORQUE_SHIFT]};
      end
      if (mag_full > {{(M_W-TLIM_W){1'b0}}, cfg.torque_limit}) begin
         mag_in = cfg.torque_limit;
      end else begin
         mag_in = mag_full[TLIM_W-1:0];
      end
      // A zero limit clamps a negative torque to zero, which counts as forward.
      dir_in = !t_ff[T_W-1] || (cfg.torque_limit == '0);
   end

   always_ff @(posedge clock) begin
      if (step.wmul) begin
         pa_ff <= pa_in;
         pb_ff <= pb_in;
      end
      if (step.wsum) begin
         t_ff <= t_in;
      end
      if (step.mag) begin
         mag_ff <= mag_in;
         dir_ff <= dir_in;
      end
   end

   assign diff = $signed({2'b00, PWM_FULL_SCALE}) - $signed({{(D_W-TLIM_W){1'b0}}, mag_ff});

   always_comb begin
      if (diff[D_W-1]) begin
         duty = '0;
      end else if (diff > $signed({{(D_W-DUTY_W){1'b0}}, DUTY_MAX})) begin
         duty = DUTY_MAX;
      end else begin
         duty = diff[DUTY_W-1:0];
      end
   end

   assign dir = dir_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/reaction_wheel_attitude_pid.sv =====
// Top level of the reaction wheel attitude controller: sequencer, lanes and output stage.
//
//   channel   direction  handshake              carries
//   req_bus   in         valid / ready          roll and pitch angles, three body rates
//   rsp_bus   out        valid / ready          four duty values, four direction bits, enable
//   csr_*     in         psel, penable, pready  eight control registers, APB-style
//
// A transaction is taken only when the sequencer is idle; it then steps through the gain
// products, their sum, the allocation products, the torque sum and the rounding of the
// torque magnitude to the output step, and the sequencer is idle again once it is loaded.
// Reset is synchronous and active high; it restores the register defaults and clears the
// roll and pitch integrals.
// A result waiting in the output register does not hold the input: a new transaction is
// accepted and computed, and only its final load waits until the output register is free.
`default_nettype none

module reaction_wheel_attitude_pid import rwap_pkg::*; (
   input  wire          clock,
   input  wire          reset,
   rwap_req_if.sink     req_bus,
   rwap_rsp_if.source   rsp_bus,
   input  wire          csr_psel,
   input  wire          csr_penable,
   input  wire          csr_pwrite,
   input  wire  [4:0]   csr_paddr,
   input  wire  [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   cfg_type   cfg;
   step_type  step;
   state_type state_ff, state_in;

   logic                   accept;
   logic                   load;
   logic signed [U_W-1:0]  u_axis [NUM_AXES];
   logic signed [U_W-1:0]  u_damp;
   logic [DUTY_W-1:0]      duty_w [NUM_WHEELS];
   logic                   dir_w  [NUM_WHEELS];

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [DUTY_W-1:0]      duty_ff [NUM_WHEELS];
   logic [NUM_WHEELS-1:0]  dir_ff;
   logic                   motor_en_ff;

   rwap_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Sequencer. One transaction at a time walks through the lane steps.
   assign req_bus.ready = (state_ff == ST_IDLE);
   assign accept        = req_bus.valid && req_bus.ready;
   assign load          = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_bus.ready);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_bus.valid) state_in = ST_MUL;
         ST_MUL:  state_in = ST_SUM;
         ST_SUM:  state_in = ST_WMUL;
         ST_WMUL: state_in = ST_WSUM;
         ST_WSUM: state_in = ST_MAG;
         ST_MAG:  state_in = ST_OUT;
         ST_OUT:  if (load) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign step.accept = accept;
   assign step.mul    = (state_ff == ST_MUL);
   assign step.sum    = (state_ff == ST_SUM);
   assign step.wmul   = (state_ff == ST_WMUL);
   assign step.wsum   = (state_ff == ST_WSUM);
   assign step.mag    = (state_ff == ST_MAG);

   // Axis lanes. Roll and pitch run the full PID; the yaw lane sees a zero error, so its
   // integral stays at zero and only the rate term survives.
   rwap_axis_lane u_roll (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .cfg    (cfg),
      .angle  (req_bus.roll_angle),
      .target (cfg.roll_target),
      .rate   (req_bus.roll_rate),
      .u      (u_axis[0])
   );

   rwap_axis_lane u_pitch (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .cfg    (cfg),
      .angle  (req_bus.pitch_angle),
      .target (cfg.pitch_target),
      .rate   (req_bus.pitch_rate),
      .u      (u_axis[1])
   );

   rwap_axis_lane u_yaw (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .cfg    (cfg),
      .angle  ('0),
      .target ('0),
      .rate   (req_bus.yaw_rate),
      .u      (u_damp)
   );

   // Wheel lanes. Wheels 0 and 2 take roll with opposite signs, wheels 1 and 3 pitch;
   // all four share the yaw damping term.
   for (genvar w = 0; w < NUM_WHEELS; w++) begin : g_wheel
      rwap_wheel_lane u_wheel (
         .clock    (clock),
         .step     (step),
         .cfg      (cfg),
         .u_axis   (u_axis[w % NUM_AXES]),
         .u_damp   (u_damp),
         .neg_axis (1'(w / NUM_AXES)),
         .duty     (duty_w[w]),
         .dir      (dir_w[w])
      );
   end

   // Merging stage: the four wheel results and the enable form one transaction.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         for (int i = 0; i < NUM_WHEELS; i++) begin
            duty_ff[i] <= duty_w[i];
            dir_ff[i]  <= dir_w[i];
         end
         motor_en_ff <= cfg.wheels_enabled;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.duty_wheel0  = duty_ff[0];
   assign rsp_bus.duty_wheel1  = duty_ff[1];
   assign rsp_bus.duty_wheel2  = duty_ff[2];
   assign rsp_bus.duty_wheel3  = duty_ff[3];
   assign rsp_bus.dir_wheel0   = dir_ff[0];
   assign rsp_bus.dir_wheel1   = dir_ff[1];
   assign rsp_bus.dir_wheel2   = dir_ff[2];
   assign rsp_bus.dir_wheel3   = dir_ff[3];
   assign rsp_bus.motor_enable = motor_en_ff;

   // An accepted transaction reaches the output step through the lane steps, with no stall between.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##6 (state_ff == ST_OUT))
      else $error("transaction did not reach the output step on time");

   // A result still waiting downstream is never overwritten.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT) && rsp_valid_ff && !rsp_bus.ready
      |=> (state_ff == ST_OUT) && $stable(dir_ff) && $stable(motor_en_ff))
      else $error("waiting result was overwritten");

   // With the wheels disabled every torque is zero, so every direction bit is set.
   a_disabled_dir: assert property (@(posedge clock) disable iff (reset)
      load && !cfg.wheels_enabled |=> (dir_ff == '1) && !motor_en_ff)
      else $error("disabled block produced a reverse direction");

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the reaction wheel attitude controller.
`timescale 1ns / 100ps

module testbench;
   import rwap_pkg::*;

   // Numbers of the control law, kept apart from the design's own constants.
   localparam longint ALLOC_MAJOR  = 39525;       // 0.6031 in Q0.16
   localparam longint ALLOC_MINOR  = 29301;       // 0.4471 in Q0.16
   localparam longint TORQUE_ONE   = 64'sd1 <<< 23;
   localparam int     PWM_FULL     = 8399;
   localparam int     DUTY_CEIL    = 16383;
   localparam int     ANGLE_MAX    = 23040;
   localparam int     RANDOM_PHASES = 10;
   localparam int     PHASE_ITEMS  = 190;
   localparam int     DRAIN_CYCLES = 20;
   localparam int     REPORT_CAP   = 50;
   // The limit is about nine times the worst case (every gap and every stall at its longest).
   localparam longint LIMIT_NS     = 30_000_000;

   // One sensor transaction and one wheel command transaction.
   typedef struct packed {
      logic signed [15:0] roll_angle;
      logic signed [15:0] pitch_angle;
      logic signed [15:0] roll_rate;
      logic signed [15:0] pitch_rate;
      logic signed [15:0] yaw_rate;
   } sensor_reading_type;

   typedef struct packed {
      logic [3:0][13:0] duty;
      logic [3:0]       dir;
      logic             enable;
   } wheel_cmd_type;

   // A row of the directed table is either a register write or a sensor transaction;
   // a transaction may carry a command typed in by hand instead of a predicted one.
   typedef struct {
      bit                 is_write;
      reg_index_type      reg_idx;
      int                 reg_value;
      sensor_reading_type reading;
      bit                 has_cmd;
      wheel_cmd_type      cmd;
   } directed_row_type;

   typedef struct {
      bit            has_cmd;
      wheel_cmd_type cmd;
   } typed_cmd_type;

   logic        clock;
   logic        reset;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [4:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   rwap_req_if req_bus ();
   rwap_rsp_if rsp_bus ();

   reaction_wheel_attitude_pid dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Shadow copy of the control registers, at their reset values, and of the
   // roll and pitch error integrals.
   int cfg_roll_target     = 0;
   int cfg_pitch_target    = 0;
   int cfg_prop_gain       = 800;
   int cfg_integ_gain      = 0;
   int cfg_rate_gain       = 240;
   int cfg_integral_limit  = 2560;
   int cfg_torque_limit    = 4000;
   bit cfg_wheels_enabled  = 1'b0;
   int angle_integral [2]  = '{0, 0};

   wheel_cmd_type      pending_cmd_q [$];   // expected commands, oldest first
   typed_cmd_type      typed_cmd_q [$];     // one entry per presented sensor transaction
   directed_row_type   directed_rows [$];
   int                 samples_accepted   = 0;
   int                 commands_received  = 0;
   int                 mismatch_count     = 0;
   int                 rsp_hold           = 0;
   bit                 no_gaps            = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Runs one control tick on the shadow state and returns the wheel command that
   // the tick should produce. The integral is updated before it is used, and it
   // keeps updating while the wheels are disabled.
   function automatic wheel_cmd_type predict_wheel_cmd(sensor_reading_type r);
      int            err [2];
      longint        rate [2];
      longint        cmd_axis [2];
      longint        cmd_yaw;
      longint        torque [4];
      longint        lim;
      longint        t;
      longint        mag;
      longint        duty;
      int            acc;
      wheel_cmd_type c;
      err[0]  = int'(r.roll_angle) - cfg_roll_target;
      err[1]  = int'(r.pitch_angle) - cfg_pitch_target;
      rate[0] = longint'(r.roll_rate);
      rate[1] = longint'(r.pitch_rate);
      for (int a = 0; a < 2; a++) begin
         acc = angle_integral[a] + err[a];
         if (acc > cfg_integral_limit) begin
            acc = cfg_integral_limit;
         end else if (acc < -cfg_integral_limit) begin
            acc = -cfg_integral_limit;
         end
         angle_integral[a] = acc;
         cmd_axis[a] = longint'(cfg_prop_gain) * err[a] + longint'(cfg_integ_gain) * acc
                     + longint'(cfg_rate_gain) * rate[a];
      end
      // Yaw has no angle error, so only the rate damping is left.
      cmd_yaw = -(longint'(cfg_rate_gain) * longint'(r.yaw_rate));
      if (cfg_wheels_enabled) begin
         torque[0] =  ALLOC_MAJOR * cmd_axis[0] + ALLOC_MINOR * cmd_yaw;
         torque[1] =  ALLOC_MAJOR * cmd_axis[1] + ALLOC_MINOR * cmd_yaw;
         torque[2] = -ALLOC_MAJOR * cmd_axis[0] + ALLOC_MINOR * cmd_yaw;
         torque[3] = -ALLOC_MAJOR * cmd_axis[1] + ALLOC_MINOR * cmd_yaw;
      end else begin
         torque = '{0, 0, 0, 0};
      end
      lim = longint'(cfg_torque_limit) * TORQUE_ONE;
      for (int w = 0; w < 4; w++) begin
         t = torque[w];
         if (t > lim) begin
            t = lim;
         end else if (t < -lim) begin
            t = -lim;
         end
         c.dir[w] = (t >= 0);
         mag = (t < 0) ? -t : t;
         // Rounding the magnitude up truncates the duty toward zero.
         mag  = (mag + TORQUE_ONE - 1) / TORQUE_ONE;
         duty = PWM_FULL - mag;
         if (duty < 0) begin
            duty = 0;
         end else if (duty > DUTY_CEIL) begin
            duty = DUTY_CEIL;
         end
         c.duty[w] = duty[13:0];
      end
      c.enable = cfg_wheels_enabled;
      return c;
   endfunction

   function automatic wheel_cmd_type uniform_cmd(int duty, logic [3:0] dirs, logic enable);
      wheel_cmd_type c;
      for (int w = 0; w < 4; w++) c.duty[w] = duty[13:0];
      c.dir    = dirs;
      c.enable = enable;
      return c;
   endfunction

   function automatic int clip(int v, int lo, int hi);
      return (v < lo) ? lo : (v > hi) ? hi : v;
   endfunction

   function automatic int signed_rand(int span);
      return int'($urandom_range(0, 2 * span)) - span;
   endfunction

   // Mostly random inside the range, with each end picked now and then.
   function automatic int pick_extreme(int lo, int hi);
      int pick;
      pick = $urandom_range(0, 7);
      if (pick == 0) return lo;
      if (pick == 1) return hi;
      return lo + int'($urandom_range(0, hi - lo));
   endfunction

   // Idle gaps are mostly short, sometimes medium and once in a while long.
   function automatic int gap_len();
      int pick;
      pick = $urandom_range(0, 15);
      if (pick < 11) return $urandom_range(1, 3);
      if (pick < 15) return $urandom_range(4, 10);
      return $urandom_range(30, 80);
   endfunction

   function automatic void add_write(reg_index_type idx, int value);
      directed_row_type row;
      row = '{reg_idx: REG_ROLL_TARGET, default: '0};
      row.is_write  = 1'b1;
      row.reg_idx   = idx;
      row.reg_value = value;
      directed_rows.push_back(row);
   endfunction

   function automatic void add_reading(int ra, int pa, int rr, int pr, int yr,
                                       bit has_cmd, wheel_cmd_type cmd);
      directed_row_type row;
      row = '{reg_idx: REG_ROLL_TARGET, default: '0};
      row.reading.roll_angle  = 16'(ra);
      row.reading.pitch_angle = 16'(pa);
      row.reading.roll_rate   = 16'(rr);
      row.reading.pitch_rate  = 16'(pr);
      row.reading.yaw_rate    = 16'(yr);
      row.has_cmd = has_cmd;
      row.cmd     = cmd;
      directed_rows.push_back(row);
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      mismatch_count++;
      // Past the cap the mismatches are still counted, just not printed.
      if (mismatch_count <= REPORT_CAP) begin
         $display("%0t ns: %s got %0d, expected %0d", $time, what, got, want);
      end
   endtask

   // Presents one sensor transaction and returns at the edge where it is accepted.
   // valid stays high on return, so a following transaction can go out back to back.
   task automatic send_reading(sensor_reading_type r, bit has_cmd, wheel_cmd_type cmd);
      if (!no_gaps && $urandom_range(0, 2) == 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap_len()) @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.roll_angle  <= r.roll_angle;
      req_bus.pitch_angle <= r.pitch_angle;
      req_bus.roll_rate   <= r.roll_rate;
      req_bus.pitch_rate  <= r.pitch_rate;
      req_bus.yaw_rate    <= r.yaw_rate;
      typed_cmd_q.push_back('{has_cmd, cmd});
      do @(posedge clock); while (!req_bus.ready);
      samples_accepted++;
   endtask

   // Writes one control register once every transaction in flight has come back,
   // then updates the shadow copy and lets the bus idle before it returns.
   task automatic csr_write(reg_index_type idx, int unsigned value);
      req_bus.valid <= 1'b0;
      while (commands_received != samples_accepted) @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         REG_ROLL_TARGET:    cfg_roll_target    = $signed(value[15:0]);
         REG_PITCH_TARGET:   cfg_pitch_target   = $signed(value[15:0]);
         REG_PROP_GAIN:      cfg_prop_gain      = value & 32'hFFF;
         REG_INTEG_GAIN:     cfg_integ_gain     = value & 32'hFFF;
         REG_RATE_GAIN:      cfg_rate_gain      = value & 32'hFFF;
         REG_INTEGRAL_LIMIT: cfg_integral_limit = value & 32'h7FFF;
         REG_TORQUE_LIMIT:   cfg_torque_limit   = value & 32'h3FFF;
         REG_WHEELS_ENABLED: cfg_wheels_enabled = value[0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // The result side stalls at random: a stall holds ready low for a gap of random
   // length. In a quiet phase ready stays high throughout.
   always @(posedge clock) begin
      if (rsp_hold != 0) begin
         rsp_hold <= rsp_hold - 1;
      end else if (!no_gaps && $urandom_range(0, 3) == 0) begin
         rsp_bus.ready <= 1'b0;
         rsp_hold      <= gap_len();
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // Watches both channels. Every accepted sensor transaction runs through the
   // predictor, so the integrals track the design even where the table supplies
   // the expected command. Every accepted wheel command is checked field by field
   // against the oldest expectation.
   always @(posedge clock) begin
      sensor_reading_type r;
      wheel_cmd_type      predicted;
      wheel_cmd_type      got;
      wheel_cmd_type      want;
      typed_cmd_type      typed;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            r.roll_angle  = req_bus.roll_angle;
            r.pitch_angle = req_bus.pitch_angle;
            r.roll_rate   = req_bus.roll_rate;
            r.pitch_rate  = req_bus.pitch_rate;
            r.yaw_rate    = req_bus.yaw_rate;
            predicted = predict_wheel_cmd(r);
            typed = typed_cmd_q.pop_front();
            pending_cmd_q.push_back(typed.has_cmd ? typed.cmd : predicted);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            commands_received++;
            got.duty[0] = rsp_bus.duty_wheel0;
            got.duty[1] = rsp_bus.duty_wheel1;
            got.duty[2] = rsp_bus.duty_wheel2;
            got.duty[3] = rsp_bus.duty_wheel3;
            got.dir     = {rsp_bus.dir_wheel3, rsp_bus.dir_wheel2,
                           rsp_bus.dir_wheel1, rsp_bus.dir_wheel0};
            got.enable  = rsp_bus.motor_enable;
            if (pending_cmd_q.size() == 0) begin
               report_mismatch("wheel command with nothing expected, count", 1, 0);
            end else begin
               want = pending_cmd_q.pop_front();
               for (int w = 0; w < 4; w++) begin
                  if (got.duty[w] !== want.duty[w]) begin
                     report_mismatch($sformatf("duty_wheel%0d", w), got.duty[w], want.duty[w]);
                  end
                  if (got.dir[w] !== want.dir[w]) begin
                     report_mismatch($sformatf("dir_wheel%0d", w), got.dir[w], want.dir[w]);
                  end
               end
               if (got.enable !== want.enable) begin
                  report_mismatch("motor_enable", got.enable, want.enable);
               end
            end
         end
      end
   end

   initial begin
      sensor_reading_type r;
      int                 angle_span;
      int                 rate_span;
      bit                 tracking;

      reset               = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.roll_angle  = '0;
      req_bus.pitch_angle = '0;
      req_bus.roll_rate   = '0;
      req_bus.pitch_rate  = '0;
      req_bus.yaw_rate    = '0;
      rsp_bus.ready       = 1'b0;
      csr_psel            = 1'b0;
      csr_penable         = 1'b0;
      csr_pwrite          = 1'b0;
      csr_paddr           = '0;
      csr_pwdata          = '0;

      // Directed table. Commands typed in by hand are the ones that can be read off
      // directly: wheels disabled, all gains zero or a zero torque limit give zero torque
      // (direction set, full-scale duty), and hard saturation gives full scale minus the torque limit.
      // Right after reset the wheels are disabled, yet the integrals still move.
      add_reading(0, 0, 0, 0, 0, 1, uniform_cmd(PWM_FULL, 4'b1111, 1'b0));
      add_reading(ANGLE_MAX, -ANGLE_MAX, 32767, -32768, -32768, 1,
                  uniform_cmd(PWM_FULL, 4'b1111, 1'b0));
      add_reading(-ANGLE_MAX, ANGLE_MAX, -32768, 32767, 32767, 1,
                  uniform_cmd(PWM_FULL, 4'b1111, 1'b0));
      add_write(REG_WHEELS_ENABLED, 1);
      // The integral gain is still zero, so a level attitude gives zero torque.
      add_reading(0, 0, 0, 0, 0, 1, uniform_cmd(PWM_FULL, 4'b1111, 1'b1));
      // Large opposite roll and pitch errors saturate every wheel.
      add_reading(ANGLE_MAX, -ANGLE_MAX, 0, 0, 0, 1,
                  uniform_cmd(PWM_FULL - 4000, 4'b1001, 1'b1));
      // Yaw damping alone pushes all four wheels the same way.
      add_reading(0, 0, 0, 0, 32767, 1, uniform_cmd(PWM_FULL - 4000, 4'b0000, 1'b1));
      add_reading(0, 0, 0, 0, -32768, 1, uniform_cmd(PWM_FULL - 4000, 4'b1111, 1'b1));
      add_reading(100, -50, 300, -200, 17, 0, '0);
      add_reading(-7, 3, -1, 1, -1, 0, '0);
      // Full gains, far targets and an integral limit as wide as the angle range.
      add_write(REG_INTEG_GAIN, 4095);
      add_write(REG_INTEGRAL_LIMIT, ANGLE_MAX);
      add_write(REG_ROLL_TARGET, ANGLE_MAX);
      add_write(REG_PITCH_TARGET, -ANGLE_MAX);
      add_write(REG_PROP_GAIN, 4095);
      add_write(REG_RATE_GAIN, 4095);
      add_write(REG_TORQUE_LIMIT, PWM_FULL);
      add_reading(-ANGLE_MAX, ANGLE_MAX, 32767, -32768, 0, 0, '0);
      add_reading(-ANGLE_MAX, ANGLE_MAX, 32767, -32768, 0, 0, '0);
      add_reading(ANGLE_MAX, -ANGLE_MAX, -32768, 32767, -32768, 0, '0);
      // A torque limit above full scale drives the duty below zero, where it saturates.
      add_write(REG_TORQUE_LIMIT, 16383);
      add_reading(-ANGLE_MAX, ANGLE_MAX, 0, 0, 0, 0, '0);
      // With a zero integral limit the integrals are pinned at zero.
      add_write(REG_INTEGRAL_LIMIT, 0);
      add_reading(22000, -22000, 5, -5, 5, 0, '0);
      add_write(REG_PROP_GAIN, 0);
      add_write(REG_INTEG_GAIN, 0);
      add_write(REG_RATE_GAIN, 0);
      add_reading(-ANGLE_MAX, ANGLE_MAX, -32768, 32767, 32767, 1,
                  uniform_cmd(PWM_FULL, 4'b1111, 1'b1));
      // A zero torque limit clamps every torque to zero whatever the gains.
      add_write(REG_PROP_GAIN, 4095);
      add_write(REG_TORQUE_LIMIT, 0);
      add_reading(ANGLE_MAX, -ANGLE_MAX, 32767, -32768, -32768, 1,
                  uniform_cmd(PWM_FULL, 4'b1111, 1'b1));
      add_write(REG_WHEELS_ENABLED, 0);
      add_reading(1, -1, 1, -1, 1, 1, uniform_cmd(PWM_FULL, 4'b1111, 1'b0));

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].is_write) begin
            csr_write(directed_rows[i].reg_idx, directed_rows[i].reg_value);
         end else begin
            send_reading(directed_rows[i].reading, directed_rows[i].has_cmd,
                         directed_rows[i].cmd);
         end
      end

      // Random phases: fresh settings each phase, every fourth phase without gaps.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         no_gaps = (phase % 4 == 3);
         if ($urandom_range(0, 3) == 0) begin
            csr_write(REG_ROLL_TARGET, pick_extreme(-ANGLE_MAX, ANGLE_MAX));
            csr_write(REG_PITCH_TARGET, pick_extreme(-ANGLE_MAX, ANGLE_MAX));
         end else begin
            csr_write(REG_ROLL_TARGET, pick_extreme(-500, 500));
            csr_write(REG_PITCH_TARGET, pick_extreme(-500, 500));
         end
         csr_write(REG_PROP_GAIN, pick_extreme(0, 4095));
         csr_write(REG_INTEG_GAIN, pick_extreme(0, 4095));
         csr_write(REG_RATE_GAIN, pick_extreme(0, 4095));
         csr_write(REG_INTEGRAL_LIMIT, pick_extreme(0, ANGLE_MAX));
         csr_write(REG_TORQUE_LIMIT,
                   ($urandom_range(0, 15) == 0) ? 16383 : pick_extreme(0, PWM_FULL));
         csr_write(REG_WHEELS_ENABLED, ($urandom_range(0, 4) != 0));

         // Most transactions hover near the targets at one of several scales, so the
         // torques land inside the limit as well as in saturation; the rest spread
         // over the whole angle range.
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            angle_span = 64 << (3 * $urandom_range(0, 3));
            rate_span  = 64 << (3 * $urandom_range(0, 3));
            tracking   = ($urandom_range(0, 9) < 7);
            r.roll_angle  = 16'(tracking ? clip(cfg_roll_target + signed_rand(angle_span),
                                                -ANGLE_MAX, ANGLE_MAX)
                                         : signed_rand(ANGLE_MAX));
            r.pitch_angle = 16'(tracking ? clip(cfg_pitch_target + signed_rand(angle_span),
                                                -ANGLE_MAX, ANGLE_MAX)
                                         : signed_rand(ANGLE_MAX));
            r.roll_rate   = 16'(clip(signed_rand(rate_span), -32768, 32767));
            r.pitch_rate  = 16'(clip(signed_rand(rate_span), -32768, 32767));
            r.yaw_rate    = 16'(clip(signed_rand(rate_span), -32768, 32767));
            send_reading(r, 1'b0, '0);
         end
      end

      req_bus.valid <= 1'b0;
      while (commands_received != samples_accepted) @(posedge clock);
      // Waiting on after the last command catches any stray one.
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("PASS reaction_wheel_attitude_pid");
      end else begin
         $display("FAIL reaction_wheel_attitude_pid");
      end
      $finish;
   end

   initial begin
      #(LIMIT_NS);
      $display("timeout: %0d of %0d wheel commands received", commands_received,
               samples_accepted);
      $display("FAIL reaction_wheel_attitude_pid");
      $finish;
   end

endmodule
